### sv/hbmd_pkg.sv
// ----------------------------------------------------------------------------
// hbmd_pkg
// Shared types and constants for the host bridge memory decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hbmd_pkg;

  typedef enum logic [1:0] {
    KIND_MEM_RD = 2'd0,
    KIND_MEM_WR = 2'd1,
    KIND_CFG_RD = 2'd2,
    KIND_CFG_WR = 2'd3
  } hbmd_kind_t;

  // config space offsets
  localparam logic [4:0] OFF_PAM_HI  = 5'b10010;  // 0x90..0x97
  localparam logic [7:0] OFF_SMRAM   = 8'h9d;
  localparam logic [7:0] OFF_ESMRAM  = 8'h9e;
  localparam logic [7:0] OFF_TOM_LO  = 8'hc4;
  localparam logic [7:0] OFF_TOM_HI  = 8'hc5;

  // register reset values and write masks
  localparam logic [7:0]  SMRAM_RESET      = 8'h02;
  localparam logic [7:0]  SMRAM_WR_MASK    = 8'hfe;
  localparam logic [7:0]  SMRAM_FORCED     = 8'h02;
  localparam logic [7:0]  ESMRAM_RESET     = 8'h38;
  localparam logic [7:0]  ESMRAM_WR_MASK   = 8'h87;
  localparam logic [7:0]  ESMRAM_FORCED    = 8'h38;
  localparam int unsigned SMRAM_LOCK_BIT   = 4;
  localparam logic [15:0] TOM_RESET        = 16'h0400;
  localparam logic [31:0] DRAM_BYTES_RESET = 32'h1000_0000;

  // address map
  localparam logic [32:0] TSEG_HALF   = 33'(512 * 1024);
  localparam logic [32:0] TSEG_FULL   = 33'(1024 * 1024);
  localparam logic [31:0] LEGACY_BASE = 32'h000a_0000;
  localparam logic [31:0] LEGACY_END  = 32'h000c_0000;
  localparam logic [31:0] PAM_END     = 32'h000f_0000;
  localparam logic [31:0] FSEG_END    = 32'h0010_0000;
  localparam logic [31:0] HOLE_BASE   = 32'h00f0_0000;
  localparam logic [31:0] HIGH_BASE   = 32'h0100_0000;
  localparam logic [31:0] ALIAS_BASE  = 32'hfeda_0000;
  localparam logic [31:0] ALIAS_END   = 32'hfedb_ffff;

  typedef struct packed {
    logic [7:0][7:0] pam;
    logic [7:0]      smram;
    logic [7:0]      esmram;
    logic [15:0]     tom;
    logic [31:0]     dram_bytes;
  } hbmd_state_t;

endpackage

`default_nettype wire

### sv/hbmd_if.sv
// ----------------------------------------------------------------------------
// hbmd_if
// Request and response channels of the host bridge memory decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbmd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [7:0]  reg_offset;
  logic [7:0]  write_data;

  modport source (output valid, kind, address, reg_offset, write_data, input ready);
  modport sink   (input valid, kind, address, reg_offset, write_data, output ready);
endinterface

interface hbmd_rsp_if;
  logic        valid;
  logic        ready;
  logic        claimed;
  logic [31:0] dram_address;
  logic [7:0]  read_data;

  modport source (output valid, claimed, dram_address, read_data, input ready);
  modport sink   (input valid, claimed, dram_address, read_data, output ready);
endinterface

`default_nettype wire

### sv/hbmd_regs.sv
// ----------------------------------------------------------------------------
// hbmd_regs
// PAM, SMRAM, ESMRAMC and top-of-memory registers with byte access, and a DRAM size register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbmd_regs (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [31:0]          cfg_wr_data,
  input  wire logic                 wr_en,
  input  wire logic [7:0]           offset,
  input  wire logic [7:0]           wr_data,
  output      logic [7:0]           rd_data,
  output      hbmd_pkg::hbmd_state_t st
);
  import hbmd_pkg::*;

  logic [7:0][7:0] pam;
  logic [7:0]      smram;
  logic [7:0]      esmram;
  logic [15:0]     tom;
  logic [31:0]     dram_bytes;
  logic            locked;

  assign locked = smram[SMRAM_LOCK_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      pam    <= '0;
      smram  <= SMRAM_RESET;
      esmram <= ESMRAM_RESET;
      tom    <= TOM_RESET;
    end else if (wr_en) begin
      if (offset[7:3] == OFF_PAM_HI) begin
        pam[offset[2:0]] <= wr_data;
      end else if (offset == OFF_SMRAM) begin
        if (!locked) smram <= (wr_data & SMRAM_WR_MASK) | SMRAM_FORCED;
      end else if (offset == OFF_ESMRAM) begin
        if (!locked) esmram <= (wr_data & ESMRAM_WR_MASK) | ESMRAM_FORCED;
      end else if (offset == OFF_TOM_LO) begin
        tom <= {tom[15:8], wr_data[7:3], 3'b000};
      end else if (offset == OFF_TOM_HI) begin
        tom <= {wr_data, tom[7:3], 3'b000};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dram_bytes <= DRAM_BYTES_RESET;
    end else if (cfg_wr_en) begin
      dram_bytes <= cfg_wr_data;
    end
  end

  always_comb begin
    rd_data = '0;
    if (offset[7:3] == OFF_PAM_HI) rd_data = pam[offset[2:0]];
    else if (offset == OFF_SMRAM)  rd_data = smram;
    else if (offset == OFF_ESMRAM) rd_data = esmram;
    else if (offset == OFF_TOM_LO) rd_data = tom[7:0];
    else if (offset == OFF_TOM_HI) rd_data = tom[15:8];
  end

  assign st.pam        = pam;
  assign st.smram      = smram;
  assign st.esmram     = esmram;
  assign st.tom        = tom;
  assign st.dram_bytes = dram_bytes;

  a_smram_forced: assert property (@(posedge clk) disable iff (rst)
    (smram & SMRAM_FORCED) == SMRAM_FORCED)
    else $error("SMRAM forced bit lost");

  a_esmram_forced: assert property (@(posedge clk) disable iff (rst)
    (esmram & ESMRAM_FORCED) == ESMRAM_FORCED)
    else $error("ESMRAMC forced bits lost");

  a_tom_aligned: assert property (@(posedge clk) disable iff (rst)
    tom[2:0] == 3'b000)
    else $error("top of memory low bits set");

  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    locked |=> locked)
    else $error("SMRAM lock cleared without reset");

endmodule

`default_nettype wire

### sv/hbmd_decode.sv
// ----------------------------------------------------------------------------
// hbmd_decode
// Memory address decode: DRAM claim and DRAM address for one access.
// ----------------------------------------------------------------------------
`default_nettype none

module hbmd_decode (
  input  wire hbmd_pkg::hbmd_state_t st,
  input  wire logic [31:0]           address,
  input  wire logic                  is_write,
  output      logic                  claimed,
  output      logic [31:0]           dram_address
);
  import hbmd_pkg::*;

  logic        alias_hit;
  logic [32:0] tseg;
  logic [32:0] top;
  logic [3:0]  seg_hi;
  logic [2:0]  pam_idx;
  logic [7:0]  pam_byte;
  logic [3:0]  pam_nib;

  assign alias_hit = st.esmram[6] && st.smram[3] &&
                     address >= ALIAS_BASE && address <= ALIAS_END;

  always_comb begin
    tseg = '0;
    if (st.esmram[0]) begin
      case (st.esmram[2:1])
        2'd2:    tseg = TSEG_HALF;
        2'd3:    tseg = TSEG_FULL;
        default: tseg = '0;
      endcase
    end
  end

  assign top = {1'b0, st.tom, 16'h0000} + tseg;

  // 16K segments: C/D/E 64K blocks map to attribute bytes 1..6
  assign seg_hi   = address[19:16] - 4'hc;
  assign pam_idx  = 3'(seg_hi[1:0] * 2) + 3'(address[15]) + 3'd1;
  assign pam_byte = st.pam[pam_idx];
  assign pam_nib  = address[14] ? pam_byte[7:4] : pam_byte[3:0];

  always_comb begin
    dram_address = address;
    if (alias_hit) begin
      claimed      = 1'b1;
      dram_address = address - ALIAS_BASE + LEGACY_BASE;
    end else if (address < LEGACY_BASE) begin
      claimed = 1'b1;
    end else if (address < LEGACY_END) begin
      claimed = st.smram[6];
    end else if (address < PAM_END) begin
      claimed = is_write ? pam_nib[1] : pam_nib[0];
    end else if (address < FSEG_END) begin
      claimed = is_write ? st.pam[0][5] : st.pam[0][4];
    end else if (address < HOLE_BASE) begin
      claimed = 1'b1;
    end else if (address < HIGH_BASE) begin
      claimed = !st.pam[7][7];
    end else begin
      claimed = ({1'b0, address} < top) && (address < st.dram_bytes);
    end
  end

endmodule

`default_nettype wire

### sv/host_bridge_memory_decoder_top.sv
// ----------------------------------------------------------------------------
// host_bridge_memory_decoder_top
// PC host bridge decode of PAM shadowing, SMRAM and top of memory.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle unless a stalled response holds
// both stages. A transaction is captured in an input register, then decoded
// (or applied to the config registers) into the output register. Config
// transactions update the register file in order with memory transactions,
// so a decode always sees every earlier config write. The user must write
// the DRAM size through cfg_wr_en / cfg_wr_data only while no transaction is
// in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module host_bridge_memory_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  hbmd_req_if.sink         req,
  hbmd_rsp_if.source       rsp,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);
  import hbmd_pkg::*;

  logic        a_valid;
  hbmd_kind_t  a_kind;
  logic [31:0] a_address;
  logic [7:0]  a_offset;
  logic [7:0]  a_data;
  logic        advance;

  logic        out_valid;
  logic        out_claimed;
  logic [31:0] out_dram_address;
  logic [7:0]  out_read_data;

  hbmd_state_t st;
  logic [7:0]  rd_data;
  logic        dec_claimed;
  logic [31:0] dec_dram_address;
  logic        is_mem;

  assign advance   = a_valid && (!out_valid || rsp.ready);
  assign req.ready = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req.ready) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      a_kind    <= hbmd_kind_t'(req.kind);
      a_address <= req.address;
      a_offset  <= req.reg_offset;
      a_data    <= req.write_data;
    end
  end

  hbmd_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_en       (advance && a_kind == KIND_CFG_WR),
    .offset      (a_offset),
    .wr_data     (a_data),
    .rd_data     (rd_data),
    .st          (st)
  );

  hbmd_decode u_decode (
    .st           (st),
    .address      (a_address),
    .is_write     (a_kind == KIND_MEM_WR),
    .claimed      (dec_claimed),
    .dram_address (dec_dram_address)
  );

  assign is_mem = (a_kind == KIND_MEM_RD) || (a_kind == KIND_MEM_WR);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_claimed      <= is_mem && dec_claimed;
      out_dram_address <= (is_mem && dec_claimed) ? dec_dram_address : '0;
      out_read_data    <= (a_kind == KIND_CFG_RD) ? rd_data : '0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.claimed      = out_claimed;
  assign rsp.dram_address = out_dram_address;
  assign rsp.read_data    = out_read_data;

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    a_valid && !advance |=> a_valid)
    else $error("input stage dropped a stalled transaction");

  a_unclaimed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_claimed |-> out_dram_address == '0)
    else $error("forwarded transaction carries a DRAM address");

  a_mem_or_cfg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_claimed && out_read_data != '0))
    else $error("response is both a claim and config read data");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the host bridge memory decoder.
// ----------------------------------------------------------------------------
// A driver feeds memory and config transactions from a queue. Each accepted
// transaction goes through a behavioral copy of the decoder and register
// file, and the predicted response is queued. A monitor compares every
// response field by field with the oldest prediction. A short directed
// sequence comes first. Random segments follow, each with a new DRAM size and
// one of three sender and receiver stall settings. One segment opens with a
// long receiver stall, and the last one exercises the SMRAM lock.
// ----------------------------------------------------------------------------

module tb;
  import hbmd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SEGMENTS     = 7;
  localparam int SEG_ITEMS    = 250;
  localparam int HOLD_CYCLES  = 400;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    hbmd_kind_t  kind;
    logic [31:0] address;
    logic [7:0]  reg_offset;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic        claimed;
    logic [31:0] dram_address;
    logic [7:0]  read_data;
  } decode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  hbmd_req_if req ();
  hbmd_rsp_if rsp ();

  host_bridge_memory_decoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // register file as the decoder should hold it
  logic [7:0]  pam_q [8];
  logic [7:0]  smram_q;
  logic [7:0]  esmram_q;
  logic [15:0] tom_q;
  logic [31:0] dram_bytes_q;

  access_t     access_q [$];
  decode_t     expected_decodes [$];
  access_t     cur_access;
  decode_t     oldest;
  logic [15:0] gen_tom;
  logic        gen_lock_ok;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;
  int          mismatches;
  int          n_mem;
  int          n_cfg;
  int          n_sizes;
  int          cycle_count;

  function automatic decode_t bridge_access(input access_t t);
    decode_t     r;
    logic [32:0] top;
    logic [31:0] a;
    logic [3:0]  seg;
    logic        wr;
    r   = '0;
    a   = t.address;
    wr  = (t.kind == KIND_MEM_WR);
    case (t.kind)
      KIND_MEM_RD, KIND_MEM_WR: begin
        n_mem++;
        top = {1'b0, tom_q, 16'h0000};
        if (esmram_q[0]) begin
          if (esmram_q[2:1] == 2'd2) top = top + TSEG_HALF;
          else if (esmram_q[2:1] == 2'd3) top = top + TSEG_FULL;
        end
        if (top > {1'b0, dram_bytes_q}) top = {1'b0, dram_bytes_q};
        seg = 4'((a - LEGACY_END) >> 14);
        if (esmram_q[6] && smram_q[3] && a >= ALIAS_BASE && a <= ALIAS_END) begin
          r.claimed = 1'b1;
          a = a - ALIAS_BASE + LEGACY_BASE;
        end else if (a < LEGACY_BASE) begin
          r.claimed = 1'b1;
        end else if (a < LEGACY_END) begin
          r.claimed = smram_q[6];
        end else if (a < PAM_END) begin
          r.claimed = pam_q[3'(seg[3:1] + 3'd1)][(seg[0] ? 4 : 0) + (wr ? 1 : 0)];
        end else if (a < FSEG_END) begin
          r.claimed = pam_q[0][wr ? 5 : 4];
        end else if (a < HOLE_BASE) begin
          r.claimed = 1'b1;
        end else if (a < HIGH_BASE) begin
          r.claimed = !pam_q[7][7];
        end else begin
          r.claimed = ({1'b0, a} < top);
        end
        if (r.claimed) r.dram_address = a;
      end
      KIND_CFG_RD: begin
        n_cfg++;
        if (t.reg_offset[7:3] == OFF_PAM_HI) r.read_data = pam_q[t.reg_offset[2:0]];
        else if (t.reg_offset == OFF_SMRAM) r.read_data = smram_q;
        else if (t.reg_offset == OFF_ESMRAM) r.read_data = esmram_q;
        else if (t.reg_offset == OFF_TOM_LO) r.read_data = tom_q[7:0];
        else if (t.reg_offset == OFF_TOM_HI) r.read_data = tom_q[15:8];
      end
      KIND_CFG_WR: begin
        n_cfg++;
        if (t.reg_offset[7:3] == OFF_PAM_HI) begin
          pam_q[t.reg_offset[2:0]] = t.write_data;
        end else if (t.reg_offset == OFF_SMRAM) begin
          if (!smram_q[SMRAM_LOCK_BIT])
            smram_q = (t.write_data & SMRAM_WR_MASK) | SMRAM_FORCED;
        end else if (t.reg_offset == OFF_ESMRAM) begin
          if (!smram_q[SMRAM_LOCK_BIT])
            esmram_q = (t.write_data & ESMRAM_WR_MASK) | ESMRAM_FORCED;
        end else if (t.reg_offset == OFF_TOM_LO) begin
          tom_q = {tom_q[15:8], t.write_data[7:3], 3'b000};
        end else if (t.reg_offset == OFF_TOM_HI) begin
          tom_q = {t.write_data, tom_q[7:3], 3'b000};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic access_t random_access();
    access_t     t;
    logic [31:0] base;
    int          pick;
    t.address    = $urandom();
    t.reg_offset = 8'($urandom_range(255));
    t.write_data = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 60) begin
      t.kind = $urandom_range(1) ? KIND_MEM_WR : KIND_MEM_RD;
      case ($urandom_range(9))
        0: t.address = $urandom_range(32'h0009_ffff);
        1: t.address = LEGACY_BASE + $urandom_range(32'h0001_ffff);
        2: t.address = LEGACY_END + $urandom_range(32'h0002_ffff);
        3: t.address = PAM_END + $urandom_range(32'h0000_ffff);
        4: t.address = FSEG_END + $urandom_range(HOLE_BASE - FSEG_END - 1);
        5: t.address = HOLE_BASE + $urandom_range(32'h000f_ffff);
        6: begin
          base = {gen_tom, 16'h0000};
          case ($urandom_range(2))
            1: base = base + 32'(TSEG_HALF);
            2: base = base + 32'(TSEG_FULL);
            default: ;
          endcase
          t.address = base + $urandom_range(15) - 8;
        end
        7: t.address = dram_bytes_q + $urandom_range(15) - 8;
        8: t.address = ALIAS_BASE - 16 + $urandom_range(32'h0002_0020);
        default: ;
      endcase
    end else begin
      t.kind = (pick < 85) ? KIND_CFG_WR : KIND_CFG_RD;
      case ($urandom_range(9))
        0, 1, 2, 3: t.reg_offset = {OFF_PAM_HI, 3'($urandom_range(7))};
        4: t.reg_offset = OFF_SMRAM;
        5: t.reg_offset = OFF_ESMRAM;
        6: t.reg_offset = OFF_TOM_LO;
        7: t.reg_offset = OFF_TOM_HI;
        default: ;
      endcase
      if (t.kind == KIND_CFG_WR) begin
        if (t.reg_offset == OFF_SMRAM && !gen_lock_ok) t.write_data[SMRAM_LOCK_BIT] = 1'b0;
        if (t.reg_offset == OFF_TOM_LO) gen_tom = {gen_tom[15:8], t.write_data[7:3], 3'b000};
        if (t.reg_offset == OFF_TOM_HI) gen_tom = {t.write_data, gen_tom[7:0]};
      end
    end
    return t;
  endfunction

  task automatic queue_access(input hbmd_kind_t kind, input logic [31:0] address,
                              input logic [7:0] reg_offset, input logic [7:0] write_data);
    access_t t;
    t = '{kind: kind, address: address, reg_offset: reg_offset, write_data: write_data};
    access_q.push_back(t);
  endtask

  task automatic wait_drained();
    while (access_q.size() != 0 || req.valid || expected_decodes.size() != 0)
      @(posedge clk);
  endtask

  task automatic load_dram_bytes(input logic [31:0] size);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    dram_bytes_q = size;
    n_sizes++;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) expected_decodes.push_back(bridge_access(cur_access));
      if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_access = access_q.pop_front();
        req.valid      <= 1'b1;
        req.kind       <= cur_access.kind;
        req.address    <= cur_access.address;
        req.reg_offset <= cur_access.reg_offset;
        req.write_data <= cur_access.write_data;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_decodes.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("%0t: response with no transaction outstanding", $realtime);
        end else begin
          oldest = expected_decodes.pop_front();
          if (rsp.claimed !== oldest.claimed || rsp.dram_address !== oldest.dram_address ||
              rsp.read_data !== oldest.read_data) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
              $display("%0t: expected claimed=%b dram=%h data=%h, got claimed=%b dram=%h data=%h",
                       $realtime, oldest.claimed, oldest.dram_address, oldest.read_data,
                       rsp.claimed, rsp.dram_address, rsp.read_data);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_decodes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [31:0] size;
    req.valid      = 1'b0;
    req.kind       = KIND_MEM_RD;
    req.address    = '0;
    req.reg_offset = '0;
    req.write_data = '0;
    rsp.ready      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    foreach (pam_q[i]) pam_q[i] = '0;
    smram_q       = SMRAM_RESET;
    esmram_q      = ESMRAM_RESET;
    tom_q         = TOM_RESET;
    dram_bytes_q  = DRAM_BYTES_RESET;
    gen_tom       = TOM_RESET;
    gen_lock_ok   = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 63;
    hold_left     = 0;
    mismatches    = 0;
    n_mem         = 0;
    n_cfg         = 0;
    n_sizes       = 0;
    cycle_count   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset map: low DRAM, legacy window closed, top at 64M
    queue_access(KIND_MEM_RD, 32'h0000_0000, 8'h00, 8'h00);
    queue_access(KIND_MEM_WR, 32'hffff_ffff, 8'h00, 8'h00);
    queue_access(KIND_MEM_RD, LEGACY_BASE, 8'h00, 8'h00);
    queue_access(KIND_CFG_RD, 32'h0000_0000, OFF_SMRAM, 8'h00);
    queue_access(KIND_CFG_RD, 32'h0000_0000, 8'h00, 8'h00);
    // open legacy, set the SMRAM alias bit, TSEG 1M, shadow segments, 15M hole, top 0xf80000
    queue_access(KIND_CFG_WR, 32'h0000_0000, OFF_SMRAM, 8'h48);
    queue_access(KIND_CFG_WR, 32'h0000_0000, OFF_ESMRAM, 8'hff);
    queue_access(KIND_CFG_WR, 32'h0000_0000, {OFF_PAM_HI, 3'd0}, 8'h30);
    queue_access(KIND_CFG_WR, 32'h0000_0000, {OFF_PAM_HI, 3'd1}, 8'h33);
    queue_access(KIND_CFG_WR, 32'h0000_0000, {OFF_PAM_HI, 3'd6}, 8'hff);
    queue_access(KIND_CFG_WR, 32'h0000_0000, {OFF_PAM_HI, 3'd7}, 8'h80);
    queue_access(KIND_CFG_WR, 32'h0000_0000, OFF_TOM_LO, 8'hff);
    queue_access(KIND_CFG_WR, 32'h0000_0000, OFF_TOM_HI, 8'h00);
    queue_access(KIND_CFG_WR, 32'h0000_0000, 8'h42, 8'haa);
    queue_access(KIND_CFG_RD, 32'h0000_0000, OFF_ESMRAM, 8'h00);
    queue_access(KIND_CFG_RD, 32'h0000_0000, OFF_TOM_LO, 8'h00);
    queue_access(KIND_MEM_RD, LEGACY_BASE, 8'h00, 8'h00);
    queue_access(KIND_MEM_WR, LEGACY_END, 8'h00, 8'h00);
    queue_access(KIND_MEM_RD, 32'h000c_4000, 8'h00, 8'h00);
    queue_access(KIND_MEM_WR, PAM_END - 1, 8'h00, 8'h00);
    queue_access(KIND_MEM_WR, PAM_END, 8'h00, 8'h00);
    queue_access(KIND_MEM_RD, HOLE_BASE, 8'h00, 8'h00);
    queue_access(KIND_MEM_RD, 32'h0107_ffff, 8'h00, 8'h00);
    queue_access(KIND_MEM_RD, 32'h0108_0000, 8'h00, 8'h00);
    queue_access(KIND_MEM_RD, ALIAS_BASE, 8'h00, 8'h00);
    queue_access(KIND_MEM_WR, ALIAS_END, 8'h00, 8'h00);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      if (seg < 2) begin
        send_idle_pct = 25;
        recv_idle_pct = 63;
      end else if (seg < 4) begin
        send_idle_pct = 63;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: size = 32'hffff_ffff;
        1: size = 32'h0000_0000;
        3: size = HIGH_BASE;
        5: size = 32'h0800_0000;
        default: size = $urandom();
      endcase
      load_dram_bytes(size);
      if (seg == 4) hold_left = HOLD_CYCLES;
      gen_lock_ok = (seg == SEGMENTS - 1);
      gen_tom     = tom_q;
      repeat (SEG_ITEMS) access_q.push_back(random_access());
    end

    // lock SMRAM, then attempt to reopen it
    queue_access(KIND_CFG_WR, 32'h0000_0000, OFF_SMRAM, 8'h10);
    queue_access(KIND_CFG_WR, 32'h0000_0000, OFF_SMRAM, 8'h48);
    queue_access(KIND_CFG_WR, 32'h0000_0000, OFF_ESMRAM, 8'h41);
    queue_access(KIND_CFG_RD, 32'h0000_0000, OFF_SMRAM, 8'h00);
    queue_access(KIND_CFG_RD, 32'h0000_0000, OFF_ESMRAM, 8'h00);
    queue_access(KIND_MEM_RD, ALIAS_BASE + 32'h100, 8'h00, 8'h00);

    wait_drained();
    repeat (4) @(posedge clk);
    $display("checked %0d memory decodes and %0d config transactions", n_mem, n_cfg);
    $display("over %0d DRAM size settings, a %0d-cycle response stall and SMRAM lock",
             n_sizes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
